### rtl/core/plane_from_three_points_defines.svh
// Assertion macros for the plane_from_three_points block.
`ifndef PLANE_FROM_THREE_POINTS_DEFINES_SVH
`define PLANE_FROM_THREE_POINTS_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication checked while out of reset.
`define PFP_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("pfp: check failed");
// Implication checked at every edge, reset included.
`define PFP_ASSERT_ALWAYS(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |-> (post)) \
        else $error("pfp: check failed");
`else
`define PFP_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define PFP_ASSERT_ALWAYS(label, clk, pre, post)
`endif
`endif

### rtl/core/pfp_pkg.sv
// Types, constants and iteration steps for the plane_from_three_points block.
`timescale 1ns / 1ps
package pfp_pkg;

    localparam int unsigned CW = 32;       // coordinate width
    localparam int unsigned FRAC = 30;     // normal fraction bits
    localparam logic [31:0] NORM_ONE = 32'h4000_0000;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
    localparam int unsigned SQ_STAGES = 16;
    localparam int unsigned DV_STAGES = 16;

    typedef struct packed {
        logic [2:0][31:0] p0;
        logic [2:0]       neg;
        logic             deg;
    } t_side;

    typedef struct packed {
        logic [63:0] x;
        logic [34:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] rem;
        logic [31:0] q;
    } t_div;

    // one digit of the square root: take two bits of x
    function automatic t_sqrt sqrt_step(t_sqrt a);
        t_sqrt       r;
        logic [34:0] rem2;
        logic [34:0] trial;
        rem2  = {a.rem[32:0], a.x[63:62]};
        trial = {1'b0, a.root, 2'b01};
        r.x   = {a.x[61:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {a.root[30:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of the restoring divide
    function automatic t_div div_step(t_div a, logic [31:0] d);
        t_div        r;
        logic [32:0] rem2;
        rem2  = {a.rem, a.num[31]};
        r.num = {a.num[30:0], 1'b0};
        if (rem2 >= {1'b0, d}) begin
            r.rem = 32'(rem2 - {1'b0, d});
            r.q   = {a.q[30:0], 1'b1};
        end else begin
            r.rem = rem2[31:0];
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### rtl/core/plane_from_three_points.sv
// Top level of the plane_from_three_points block: plane through three points.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  s_axis   | in  | tvalid / tready     | tdata: nine Q16.16 coordinates
//  m_axis   | out | tvalid / tready     | tdata: normal x,y,z Q1.30, offset
//           |     |                     | tuser: degenerate flag
//  cfg      | in  | valid / ready       | data: degenerate threshold
//
//  An item passes from input accept to output valid through 44 register stages;
//  one item enters every cycle while the pipe is not stalled. Most of the depth is the
//  16-stage square root and the 16-stage restoring divide, two digits per stage each.
//  Reset clears every stage valid bit and sets the threshold to 1.
//  All stages advance together when the output register is empty or taken;
//  a stall freezes the whole pipe, so no item is lost or repeated.
`timescale 1ns / 1ps
`include "plane_from_three_points_defines.svh"
module plane_from_three_points (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (32 bits each)
    input  logic [287:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // normal_x, normal_y, normal_z, plane_offset (32 bits each)
    output logic [127:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    localparam int unsigned NSTAGE = 8 + pfp_pkg::SQ_STAGES + pfp_pkg::DV_STAGES + 4;
    localparam int unsigned SQ0 = 8;
    localparam int unsigned DV0 = SQ0 + pfp_pkg::SQ_STAGES;

    logic              en;
    logic [NSTAGE-1:0] r_vld;
    logic [31:0]       r_thr;

    // advance the whole pipe whenever the output slot frees
    assign en              = !r_vld[NSTAGE-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= 32'd1;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTAGE-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // stage 1: edge vectors, exact in 33 bits
    logic [2:0][31:0]        r1_p0;
    logic signed [2:0][32:0] r1_u, r1_v;
    // stage 2: cross-product partial products
    logic [2:0][31:0]        r2_p0;
    logic signed [5:0][65:0] r2_prod;
    // stage 3: cross product
    logic [2:0][31:0]        r3_p0;
    logic signed [2:0][66:0] r3_c;
    // stage 4: magnitudes and sign
    logic [2:0][31:0]        r4_p0;
    logic [2:0][65:0]        r4_a;
    logic [2:0]              r4_neg;
    logic [65:0]             r4_or;
    // stage 5: bit length and collinear test
    logic [2:0][65:0]        r5_a;
    logic [6:0]              r5_bl;
    pfp_pkg::t_side          r5_side;
    // stage 6: magnitudes scaled to 30 bits
    logic [2:0][29:0]        r6_mag;
    pfp_pkg::t_side          r6_side;
    // stage 7: squares
    logic [2:0][29:0]        r7_mag;
    logic [2:0][59:0]        r7_sq;
    pfp_pkg::t_side          r7_side;
    // stage 8: four times the squared length
    logic [2:0][29:0]        r8_mag;
    logic [63:0]             r8_x;
    pfp_pkg::t_side          r8_side;

    logic signed [65:0] n_ue [3];
    logic signed [65:0] n_ve [3];
    logic [6:0]         n_bl;
    logic [33:0]        n_len2;
    logic               n_small;
    logic [95:0]        n_shift [3];

    always_comb begin
        // elements of a packed array read unsigned: extend by sign explicitly
        for (int k = 0; k < 3; k++) begin
            n_ue[k] = 66'($signed(r1_u[k]));
            n_ve[k] = 66'($signed(r1_v[k]));
        end
        n_bl = '0;
        for (int b = 0; b < 66; b++) begin
            if (r4_or[b]) begin
                n_bl = 7'(b + 1);
            end
        end
        n_small = 1'b1;
        n_len2  = '0;
        for (int k = 0; k < 3; k++) begin
            if (r4_a[k][65:16] != '0) begin
                n_small = 1'b0;
            end
            n_len2 = n_len2 + 34'(r4_a[k][15:0] * r4_a[k][15:0]);
        end
        for (int k = 0; k < 3; k++) begin
            n_shift[k] = {r5_a[k], 30'b0} >> r5_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_p0[k] <= i_s_axis_tdata[32*k +: 32];
                r1_u[k]  <= {i_s_axis_tdata[32*(k+3)+31], i_s_axis_tdata[32*(k+3) +: 32]}
                          - {i_s_axis_tdata[32*k+31], i_s_axis_tdata[32*k +: 32]};
                r1_v[k]  <= {i_s_axis_tdata[32*(k+6)+31], i_s_axis_tdata[32*(k+6) +: 32]}
                          - {i_s_axis_tdata[32*k+31], i_s_axis_tdata[32*k +: 32]};
            end
            r2_p0      <= r1_p0;
            r2_prod[0] <= n_ue[1] * n_ve[2];
            r2_prod[1] <= n_ue[2] * n_ve[1];
            r2_prod[2] <= n_ue[2] * n_ve[0];
            r2_prod[3] <= n_ue[0] * n_ve[2];
            r2_prod[4] <= n_ue[0] * n_ve[1];
            r2_prod[5] <= n_ue[1] * n_ve[0];

            r3_p0 <= r2_p0;
            for (int k = 0; k < 3; k++) begin
                r3_c[k] <= {r2_prod[2*k][65], r2_prod[2*k]}
                         - {r2_prod[2*k+1][65], r2_prod[2*k+1]};
            end

            r4_p0 <= r3_p0;
            for (int k = 0; k < 3; k++) begin
                r4_neg[k] <= r3_c[k][66];
                r4_a[k]   <= r3_c[k][66] ? 66'(-r3_c[k]) : r3_c[k][65:0];
            end
            r4_or <= (r3_c[0][66] ? 66'(-r3_c[0]) : r3_c[0][65:0])
                   | (r3_c[1][66] ? 66'(-r3_c[1]) : r3_c[1][65:0])
                   | (r3_c[2][66] ? 66'(-r3_c[2]) : r3_c[2][65:0]);

            r5_a         <= r4_a;
            r5_bl        <= n_bl;
            r5_side.p0   <= r4_p0;
            r5_side.neg  <= r4_neg;
            r5_side.deg  <= n_small && (n_len2 <= {2'b00, r_thr});

            for (int k = 0; k < 3; k++) begin
                r6_mag[k] <= n_shift[k][29:0];
            end
            r6_side <= r5_side;

            r7_mag  <= r6_mag;
            for (int k = 0; k < 3; k++) begin
                r7_sq[k] <= r6_mag[k] * r6_mag[k];
            end
            r7_side <= r6_side;

            r8_mag  <= r7_mag;
            r8_x    <= {62'(r7_sq[0] + r7_sq[1] + r7_sq[2]), 2'b00};
            r8_side <= r7_side;
        end
    end

    // square root: two digits a stage
    pfp_pkg::t_sqrt   r_sq      [pfp_pkg::SQ_STAGES];
    logic [2:0][29:0] r_sq_mag  [pfp_pkg::SQ_STAGES];
    pfp_pkg::t_side   r_sq_side [pfp_pkg::SQ_STAGES];
    pfp_pkg::t_sqrt   n_sq      [pfp_pkg::SQ_STAGES];
    pfp_pkg::t_sqrt   n_sq_in;

    always_comb begin
        for (int j = 0; j < pfp_pkg::SQ_STAGES; j++) begin
            if (j == 0) begin
                n_sq_in.x    = r8_x;
                n_sq_in.rem  = '0;
                n_sq_in.root = '0;
            end else begin
                n_sq_in = r_sq[j-1];
            end
            n_sq[j] = pfp_pkg::sqrt_step(pfp_pkg::sqrt_step(n_sq_in));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < pfp_pkg::SQ_STAGES; j++) begin
                r_sq[j] <= n_sq[j];
                if (j == 0) begin
                    r_sq_mag[j]  <= r8_mag;
                    r_sq_side[j] <= r8_side;
                end else begin
                    r_sq_mag[j]  <= r_sq_mag[j-1];
                    r_sq_side[j] <= r_sq_side[j-1];
                end
            end
        end
    end

    // divide each magnitude times 2^31 by the root: two quotient bits a stage
    pfp_pkg::t_div  r_dv      [pfp_pkg::DV_STAGES][3];
    logic [31:0]    r_dv_s    [pfp_pkg::DV_STAGES];
    pfp_pkg::t_side r_dv_side [pfp_pkg::DV_STAGES];
    pfp_pkg::t_div  n_dv      [pfp_pkg::DV_STAGES][3];
    pfp_pkg::t_div  n_dv_in;
    logic [31:0]    n_dv_s;

    always_comb begin
        for (int j = 0; j < pfp_pkg::DV_STAGES; j++) begin
            n_dv_s = (j == 0) ? r_sq[pfp_pkg::SQ_STAGES-1].root : r_dv_s[j-1];
            for (int k = 0; k < 3; k++) begin
                if (j == 0) begin
                    n_dv_in.num = {r_sq_mag[pfp_pkg::SQ_STAGES-1][k][0], 31'b0};
                    n_dv_in.rem = {3'b000, r_sq_mag[pfp_pkg::SQ_STAGES-1][k][29:1]};
                    n_dv_in.q   = '0;
                end else begin
                    n_dv_in = r_dv[j-1][k];
                end
                n_dv[j][k] = pfp_pkg::div_step(pfp_pkg::div_step(n_dv_in, n_dv_s), n_dv_s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < pfp_pkg::DV_STAGES; j++) begin
                r_dv[j] <= n_dv[j];
                if (j == 0) begin
                    r_dv_s[j]    <= r_sq[pfp_pkg::SQ_STAGES-1].root;
                    r_dv_side[j] <= r_sq_side[pfp_pkg::SQ_STAGES-1];
                end else begin
                    r_dv_s[j]    <= r_dv_s[j-1];
                    r_dv_side[j] <= r_dv_side[j-1];
                end
            end
        end
    end

    // signed normal, offset products, rounding sum, output
    logic signed [2:0][31:0] r9_nrm;
    pfp_pkg::t_side          r9_side;
    logic signed [2:0][63:0] r10_prod;
    logic signed [2:0][31:0] r10_nrm;
    logic                    r10_deg;
    logic signed [35:0]      r11_sh;
    logic signed [2:0][31:0] r11_nrm;
    logic                    r11_deg;
    logic [127:0]            r_out_data;
    logic                    r_out_deg;

    logic signed [63:0] n_ne [3];
    logic signed [63:0] n_pe [3];
    logic signed [65:0] n_acc;
    logic [31:0]        n_off;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ne[k] = 64'($signed(r9_nrm[k]));
            n_pe[k] = 64'($signed(r9_side.p0[k]));
        end
        n_acc = 66'($signed(r10_prod[0])) + 66'($signed(r10_prod[1]))
              + 66'($signed(r10_prod[2]))
              + 66'(64'sd1 <<< (pfp_pkg::FRAC - 1));
        if (r11_sh > 36'sh0_7FFF_FFFF) begin
            n_off = pfp_pkg::SAT_POS;
        end else if (r11_sh < -36'sh0_8000_0000) begin
            n_off = pfp_pkg::SAT_NEG;
        end else begin
            n_off = r11_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r9_nrm[k] <= r_dv_side[pfp_pkg::DV_STAGES-1].neg[k]
                           ? 32'(-r_dv[pfp_pkg::DV_STAGES-1][k].q)
                           : r_dv[pfp_pkg::DV_STAGES-1][k].q;
            end
            r9_side <= r_dv_side[pfp_pkg::DV_STAGES-1];

            for (int k = 0; k < 3; k++) begin
                r10_prod[k] <= n_ne[k] * n_pe[k];
            end
            r10_nrm <= r9_nrm;
            r10_deg <= r9_side.deg;

            r11_sh  <= n_acc[65:30];
            r11_nrm <= r10_nrm;
            r11_deg <= r10_deg;

            // drop the computed plane for collinear points
            if (r11_deg) begin
                r_out_data <= {32'd0, 32'd0, 32'd0, pfp_pkg::NORM_ONE};
            end else begin
                r_out_data <= {n_off, r11_nrm[2], r11_nrm[1], r11_nrm[0]};
            end
            r_out_deg <= r11_deg;
        end
    end

    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_deg;

    `PFP_ASSERT_IMPLY(a_deg_plane, i_clk, i_rst_n, o_m_axis_tvalid && r_out_deg,
        r_out_data == {32'd0, 32'd0, 32'd0, pfp_pkg::NORM_ONE})
    `PFP_ASSERT_IMPLY(a_norm_range, i_clk, i_rst_n, o_m_axis_tvalid && !r_out_deg,
        ($signed(r_out_data[31:0]) <= $signed(pfp_pkg::NORM_ONE))
        && ($signed(r_out_data[31:0]) >= -$signed(pfp_pkg::NORM_ONE)))
    `PFP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, ##1 (r_vld == '0))
    `PFP_ASSERT_IMPLY(a_stall_hold, i_clk, i_rst_n, $past(o_m_axis_tvalid && !i_m_axis_tready) && $past(i_rst_n),
        $stable(r_vld) && !o_s_axis_tready == o_m_axis_tvalid && !i_m_axis_tready || o_s_axis_tready)

endmodule

### bench/plane_from_three_points_tb.sv
// Self-checking bench for the plane_from_three_points block.
`timescale 1ns / 1ps
module plane_from_three_points_tb;

    // Pipeline depth taken from the block header; drain() adds a margin.
    localparam int PIPE_LAT = 44;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] off;
        logic        deg;
    } t_plane;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [287:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;

    plane_from_three_points dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Triangles waiting for the driver, planes waiting for the monitor.
    logic [287:0] tri_queue[$];
    t_plane       plane_queue[$];
    logic [31:0]  threshold;      // predictor copy of the register
    int           mismatches = 0;
    int           cycles = 0;
    bit           long_hold;      // receiver hold-off request
    bit           gaps_on;

    // Predict the plane for one triangle at the current threshold.
    function automatic t_plane predict_plane(logic [287:0] pts);
        logic signed [31:0]  p[9];
        logic signed [32:0]  u[3], v[3];
        logic signed [67:0]  c[3];
        logic [66:0]         a[3];
        logic [66:0]         m;
        logic [63:0]         mag[3];
        logic [63:0]         len2, s, q;
        logic [127:0]        num;
        logic signed [127:0] acc, sh;
        logic signed [63:0]  n[3];
        bit                  tiny;
        int                  bl;
        t_plane              r;
        for (int i = 0; i < 9; i++) p[i] = pts[32*i +: 32];
        for (int i = 0; i < 3; i++) begin
            u[i] = 33'(p[3+i]) - 33'(p[i]);
            v[i] = 33'(p[6+i]) - 33'(p[i]);
        end
        c[0] = 68'(u[1]) * 68'(v[2]) - 68'(u[2]) * 68'(v[1]);
        c[1] = 68'(u[2]) * 68'(v[0]) - 68'(u[0]) * 68'(v[2]);
        c[2] = 68'(u[0]) * 68'(v[1]) - 68'(u[1]) * 68'(v[0]);
        tiny = 1'b1;
        len2 = 0;
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = c[i] < 0 ? 67'(-c[i]) : 67'(c[i]);
            if (a[i] >= 67'h10000) tiny = 1'b0;
            else len2 += 64'(a[i]) * 64'(a[i]);
            for (int b = 0; b < 67; b++) if (a[i][b]) bl = (b + 1 > bl) ? b + 1 : bl;
        end
        if (tiny && len2 <= 64'(threshold)) begin
            r = '{pfp_pkg::NORM_ONE, 32'd0, 32'd0, 32'd0, 1'b1};
            return r;
        end
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            m = (bl > 30) ? a[i] >> (bl - 30) : a[i] << (30 - bl);
            mag[i] = 64'(m);
            len2 += mag[i] * mag[i];
        end
        // Integer square root by bit pairs.
        begin
            logic [63:0] x, rt, bt;
            x = len2 << 2;
            rt = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt >>= 2;
            while (bt != 0) begin
                if (x >= rt + bt) begin
                    x -= rt + bt;
                    rt = (rt >> 1) + bt;
                end else begin
                    rt >>= 1;
                end
                bt >>= 2;
            end
            s = rt;
        end
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            num = 128'(mag[i]) << (pfp_pkg::FRAC + 1);
            q = 64'(num / 128'(s));
            n[i] = c[i] < 0 ? -$signed(q) : $signed(q);
            acc += 128'(n[i]) * 128'(p[i]);
        end
        acc += 128'sd1 <<< (pfp_pkg::FRAC - 1);
        sh = acc >>> pfp_pkg::FRAC;
        r.nx = n[0][31:0];
        r.ny = n[1][31:0];
        r.nz = n[2][31:0];
        if (sh > 128'sd2147483647) r.off = pfp_pkg::SAT_POS;
        else if (sh < -128'sd2147483648) r.off = pfp_pkg::SAT_NEG;
        else r.off = sh[31:0];
        r.deg = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [287:0] pack_tri(logic [31:0] c[9]);
        logic [287:0] d;
        for (int i = 0; i < 9; i++) d[32*i +: 32] = c[i];
        return d;
    endfunction

    // Input acceptance sampled at the rising edge; predict on acceptance.
    logic o_s_axis_tready_q;
    always @(posedge i_clk) begin
        o_s_axis_tready_q <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            plane_queue.push_back(predict_plane(i_s_axis_tdata));
    end

    // Driver: offer the head of the queue, pause between items at random while gaps are on.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready_q) begin
                void'(tri_queue.pop_front());
                if (gaps_on) send_gap = ($urandom_range(0, 9) == 0) ?
                    $urandom_range(5, 40) : $urandom_range(0, 2);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (tri_queue.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= tri_queue[0];
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern; one long hold-off is counted here on request.
    int hold_left;
    int long_left;
    bit long_taken;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left = 0;
            long_left = 0;
            long_taken = 1'b0;
        end else if (long_hold && !long_taken) begin
            long_taken = 1'b1;
            long_left = LONG_HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (long_left > 0) begin
            long_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (gaps_on && $urandom_range(0, 5) == 0)
                hold_left = ($urandom_range(0, 9) == 0) ?
                    $urandom_range(5, 40) : $urandom_range(1, 2);
        end
    end

    // Monitor: compare each accepted plane with the oldest prediction.
    always @(posedge i_clk) begin
        t_plane got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                   o_m_axis_tdata[95:64], o_m_axis_tdata[127:96], o_m_axis_tuser[0]};
            if (plane_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected plane %h", got);
            end else begin
                want = plane_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plane mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                            want.nx, want.ny, want.nz, want.off, want.deg,
                            got.nx, got.ny, got.nz, got.off, got.deg);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write the threshold once the pipe has drained.
    task automatic write_threshold(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (tri_queue.size() != 0 || plane_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic add_tri(logic [31:0] c[9]);
        tri_queue.push_back(pack_tri(c));
    endtask

    task automatic random_phase(int count);
        logic [31:0] c[9];
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) c[i] = rand_coord(kind);
            // make some collinear or coincident triangles
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
                1: for (int i = 0; i < 3; i++) c[6+i] = 32'(2 * $signed(c[3+i]) - $signed(c[i]));
                2: for (int i = 0; i < 3; i++) c[6+i] = c[3+i] + 32'($urandom_range(0, 1));
                default: ;
            endcase
            add_tri(c);
        end
    endtask

    initial begin
        logic [31:0] c[9];
        logic [31:0] maxv, minv;
        maxv = 32'h7FFF_FFFF;
        minv = 32'h8000_0000;
        long_hold = 0;
        gaps_on = 0;
        threshold = 32'd1;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: coincident, collinear, axis planes, extremes, near threshold.
        c = '{default: 32'd0};
        add_tri(c);
        c = '{32'h1_0000, 0, 0, 32'h2_0000, 0, 0, 32'h3_0000, 0, 0};
        add_tri(c);
        c = '{0, 0, 32'h5_0000, 32'h1_0000, 0, 32'h5_0000, 0, 32'h1_0000, 32'h5_0000};
        add_tri(c);
        c = '{32'hFFFD_0000, 0, 0, 32'hFFFD_0000, 32'h1_0000, 0, 32'hFFFD_0000, 0, 32'h1_0000};
        add_tri(c);
        c = '{maxv, maxv, maxv, minv, maxv, minv, maxv, minv, minv};
        add_tri(c);
        c = '{minv, minv, minv, maxv, minv, maxv, minv, maxv, maxv};
        add_tri(c);
        c = '{maxv, minv, maxv, minv, minv, maxv, maxv, maxv, minv};
        add_tri(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};       // |c|^2 = 1, on the threshold
        add_tri(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 2, 0};       // just above reset threshold
        add_tri(c);
        c = '{0, 0, 0, 32'hFFFF, 0, 0, 0, 32'hFFFF, 0};  // edges at the 16-bit limit; the cross product is not small
        add_tri(c);
        c = '{0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0};
        add_tri(c);
        c = '{maxv, maxv, maxv, 0, 0, 0, maxv, 0, 0};
        add_tri(c);
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0};
        add_tri(c);
        drain();

        // Random with idling and a long receiver hold-off.
        gaps_on = 1;
        random_phase(100);
        long_hold = 1;
        random_phase(500);
        drain();

        write_threshold(32'd0);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        add_tri(c);
        random_phase(450);
        drain();

        write_threshold(32'hFFFF_FFFF);
        c = '{0, 0, 0, 32'hFFFF, 0, 0, 0, 32'hFFFF, 0};
        add_tri(c);
        random_phase(450);
        drain();

        write_threshold(32'd2000);
        random_phase(300);
        gaps_on = 0;
        random_phase(200);
        drain();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
